[src/clp_pkg.sv]
// Shared types and constants for the clear label placer.
`default_nettype none

package clp_pkg;

    // Opcodes of an input transfer
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MAX_Y = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [14:0]        CLEARANCE_RST  = 15'd128;
    localparam logic signed [15:0] VIEW_MIN_X_RST = 16'sd0;
    localparam logic signed [15:0] VIEW_MIN_Y_RST = 16'sd0;
    localparam logic signed [15:0] VIEW_MAX_X_RST = 16'sd20480;
    localparam logic signed [15:0] VIEW_MAX_Y_RST = 16'sd11520;

    // 1/sqrt(2) in Q0.16 and the rounding half
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
    localparam logic [30:0] ROUND_HALF    = 31'd32768;

    // Direction steps, east first, counterclockwise, y grows downward
    localparam int NUM_DIRS = 8;
    localparam logic signed [1:0] DIR_X [NUM_DIRS] =
        '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] DIR_Y [NUM_DIRS] =
        '{2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] anchor_x;
        logic signed [15:0] anchor_y;
        logic [14:0]        label_w;
        logic [14:0]        label_h;
        logic signed [15:0] rect_x0;
        logic signed [15:0] rect_y0;
        logic signed [15:0] rect_x1;
        logic signed [15:0] rect_y1;
    } clp_req_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               found_clear;
    } clp_rsp_t;

endpackage

`default_nettype wire

[src/clear_label_placer_core.sv]
// Top level of the clear label placer: rectangle store and placement sequencer.
//
// Usage: one request channel (req, req_valid, req_stall) carries three kinds
// of transfer. A clear empties the store and a load appends one placed
// rectangle (dropped when the store holds MAX_PLACED entries); neither
// gives a response. A place request gives exactly one response on the rsp
// channel (rsp, rsp_valid, rsp_stall) with the chosen corner.
// A place request runs a setup step (S_DIAG), then for each tried direction
// forms the candidate (S_CAND, S_FAR) and scans the stored rectangles, read
// one a cycle from the store's single read port (S_SCAN), then posts the
// result (S_RESULT). req_stall is high while a place request is in progress.
// A finished response sits in the output register; while the receiver stalls
// it, clears and loads are still taken, and the next place request holds in
// S_RESULT until the register frees up.
// Reset empties the store, drops any pending response and restores the
// configuration registers (clearance 128, viewport 0,0 to 20480,11520).
// Configuration writes via cfg_we/cfg_index/cfg_data take effect at once.
`default_nettype none

module clear_label_placer_core #(
    parameter int MAX_PLACED = 64
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   req_valid,
    output logic                                  req_stall,
    input  clp_pkg::clp_req_t                     req,
    output logic                                  rsp_valid,
    input  wire                                   rsp_stall,
    output clp_pkg::clp_rsp_t                     rsp,
    input  wire                                   cfg_we,
    input  wire  [clp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire  [clp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int IDX_W = (MAX_PLACED > 1) ? $clog2(MAX_PLACED) : 1;
    localparam int CNT_W = $clog2(MAX_PLACED + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIAG   = 3'd1;
    localparam logic [2:0] S_CAND   = 3'd2;
    localparam logic [2:0] S_FAR    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    // Clamp into [lo, hi] in the order of std::clamp, then saturate to 16 bits
    function automatic logic signed [15:0] clamp_sat(
        input logic signed [17:0] v,
        input logic signed [15:0] lo,
        input logic signed [16:0] hi
    );
        logic signed [17:0] lo_e;
        logic signed [17:0] hi_e;
        logic signed [17:0] c;
        lo_e = 18'(lo);
        hi_e = 18'(hi);
        if (v < lo_e)
            c = lo_e;
        else if (v > hi_e)
            c = hi_e;
        else
            c = v;
        if (c > 18'sd32767)
            return 16'sh7FFF;
        else if (c < -18'sd32768)
            return 16'sh8000;
        else
            return c[15:0];
    endfunction

    // Step an anchor coordinate by -1, 0 or +1 times the offset
    function automatic logic signed [17:0] step_coord(
        input logic signed [15:0] a,
        input logic signed [1:0]  d,
        input logic [14:0]        off
    );
        logic signed [17:0] a_e;
        logic signed [17:0] off_e;
        a_e   = 18'(a);
        off_e = signed'({3'b000, off});
        if (d == 2'sd1)
            return a_e + off_e;
        else if (d == -2'sd1)
            return a_e - off_e;
        else
            return a_e;
    endfunction

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [2:0]       dir_reg, dir_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Configuration registers
    logic [14:0]        clearance_reg;
    logic signed [15:0] view_min_x_reg, view_min_y_reg;
    logic signed [15:0] view_max_x_reg, view_max_y_reg;

    // Query and candidate payload
    logic signed [15:0] q_ax_reg, q_ax_next;
    logic signed [15:0] q_ay_reg, q_ay_next;
    logic [14:0]        q_w_reg, q_w_next;
    logic [14:0]        q_h_reg, q_h_next;
    logic [14:0]        diag_reg, diag_next;
    logic signed [16:0] hi_x_reg, hi_x_next;
    logic signed [16:0] hi_y_reg, hi_y_next;
    logic signed [15:0] cx_reg, cx_next;
    logic signed [15:0] cy_reg, cy_next;
    logic signed [16:0] cx1_reg, cx1_next;
    logic signed [16:0] cy1_reg, cy1_next;
    logic signed [15:0] res_x_reg, res_x_next;
    logic signed [15:0] res_y_reg, res_y_next;
    logic               res_found_reg, res_found_next;
    clp_pkg::clp_rsp_t  rsp_reg, rsp_next;

    // Rectangle store
    logic [63:0]        placed_mem [MAX_PLACED];
    logic [63:0]        rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               store_we;

    logic               req_xfer;
    logic [30:0]        diag_prod;
    logic [14:0]        off_x, off_y;
    logic               is_diag;
    logic signed [15:0] st_x0, st_y0, st_x1, st_y1;
    logic               hit;
    logic               last_entry;
    logic               rsp_free;

    assign req_stall = (state_reg != S_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Diagonal offset: clearance / sqrt(2), rounded half up
    assign diag_prod = 31'(clearance_reg) * 31'(clp_pkg::INV_SQRT2_Q16) + clp_pkg::ROUND_HALF;

    // Offsets of the current direction
    assign is_diag = (clp_pkg::DIR_X[dir_reg] != 2'sd0) && (clp_pkg::DIR_Y[dir_reg] != 2'sd0);
    assign off_x   = is_diag ? diag_reg : clearance_reg;
    assign off_y   = off_x;

    // Unpack the stored rectangle under test
    assign st_x0 = $signed(rd_data_reg[15:0]);
    assign st_y0 = $signed(rd_data_reg[31:16]);
    assign st_x1 = $signed(rd_data_reg[47:32]);
    assign st_y1 = $signed(rd_data_reg[63:48]);

    // Strict overlap of stored rectangle and candidate
    assign hit = (17'(st_x0) < cx1_reg) && (17'(st_x1) > 17'(cx_reg)) &&
                 (17'(st_y0) < cy1_reg) && (17'(st_y1) > 17'(cy_reg));

    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign store_we = req_xfer && (req.opcode == clp_pkg::OP_LOAD) &&
                      (count_reg < CNT_W'(MAX_PLACED));

    // Read address: first entry when forming the candidate, else the next one
    always_comb
    begin
        if (state_reg == S_SCAN && idx_reg != IDX_W'(MAX_PLACED - 1))
            rd_addr = idx_reg + IDX_W'(1);
        else
            rd_addr = '0;
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        q_ax_next      = q_ax_reg;
        q_ay_next      = q_ay_reg;
        q_w_next       = q_w_reg;
        q_h_next       = q_h_reg;
        diag_next      = diag_reg;
        hi_x_next      = hi_x_reg;
        hi_y_next      = hi_y_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cx1_next       = cx1_reg;
        cy1_next       = cy1_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_found_next = res_found_reg;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.opcode)
                        clp_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        clp_pkg::OP_LOAD:
                        begin
                            if (store_we)
                                count_next = count_reg + CNT_W'(1);
                        end
                        clp_pkg::OP_PLACE:
                        begin
                            q_ax_next  = req.anchor_x;
                            q_ay_next  = req.anchor_y;
                            q_w_next   = req.label_w;
                            q_h_next   = req.label_h;
                            dir_next   = '0;
                            state_next = S_DIAG;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIAG:
            begin
                // Set up the diagonal offset and the clamp upper bounds
                diag_next  = diag_prod[30:16];
                hi_x_next  = 17'(view_max_x_reg) - signed'({2'b00, q_w_reg});
                hi_y_next  = 17'(view_max_y_reg) - signed'({2'b00, q_h_reg});
                state_next = S_CAND;
            end
            S_CAND:
            begin
                // Offset the anchor and clamp into the viewport
                cx_next = clamp_sat(step_coord(q_ax_reg, clp_pkg::DIR_X[dir_reg], off_x),
                                    view_min_x_reg, hi_x_reg);
                cy_next = clamp_sat(step_coord(q_ay_reg, clp_pkg::DIR_Y[dir_reg], off_y),
                                    view_min_y_reg, hi_y_reg);
                state_next = S_FAR;
            end
            S_FAR:
            begin
                // Form the far corner and start the store scan
                cx1_next = 17'(cx_reg) + signed'({2'b00, q_w_reg});
                cy1_next = 17'(cy_reg) + signed'({2'b00, q_h_reg});
                idx_next = '0;
                if (count_reg == '0)
                begin
                    res_x_next     = cx_reg;
                    res_y_next     = cy_reg;
                    res_found_next = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    // Drop this candidate; fall back to the anchor after the last one
                    if (dir_reg == 3'(clp_pkg::NUM_DIRS - 1))
                    begin
                        res_x_next     = q_ax_reg;
                        res_y_next     = q_ay_reg;
                        res_found_next = 1'b0;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        dir_next   = dir_reg + 3'd1;
                        state_next = S_CAND;
                    end
                end
                else if (last_entry)
                begin
                    res_x_next     = cx_reg;
                    res_y_next     = cy_reg;
                    res_found_next = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_RESULT:
            begin
                // Hold until the output register is free, then post the result
                if (rsp_free)
                begin
                    rsp_next.pos_x       = res_x_reg;
                    rsp_next.pos_y       = res_y_reg;
                    rsp_next.found_clear = res_found_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dir_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            clearance_reg  <= clp_pkg::CLEARANCE_RST;
            view_min_x_reg <= clp_pkg::VIEW_MIN_X_RST;
            view_min_y_reg <= clp_pkg::VIEW_MIN_Y_RST;
            view_max_x_reg <= clp_pkg::VIEW_MAX_X_RST;
            view_max_y_reg <= clp_pkg::VIEW_MAX_Y_RST;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    clp_pkg::REG_CLEARANCE:  clearance_reg  <= cfg_data[14:0];
                    clp_pkg::REG_VIEW_MIN_X: view_min_x_reg <= $signed(cfg_data);
                    clp_pkg::REG_VIEW_MIN_Y: view_min_y_reg <= $signed(cfg_data);
                    clp_pkg::REG_VIEW_MAX_X: view_max_x_reg <= $signed(cfg_data);
                    clp_pkg::REG_VIEW_MAX_Y: view_max_y_reg <= $signed(cfg_data);
                    default:                 clearance_reg  <= clearance_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_ax_reg      <= q_ax_next;
        q_ay_reg      <= q_ay_next;
        q_w_reg       <= q_w_next;
        q_h_reg       <= q_h_next;
        diag_reg      <= diag_next;
        hi_x_reg      <= hi_x_next;
        hi_y_reg      <= hi_y_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cx1_reg       <= cx1_next;
        cy1_reg       <= cy1_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_found_reg <= res_found_next;
        rsp_reg       <= rsp_next;
    end

    // Rectangle store: append on load, one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (store_we)
            placed_mem[count_reg[IDX_W-1:0]] <= {req.rect_y1, req.rect_x1,
                                                 req.rect_y0, req.rect_x0};
        rd_data_reg <= placed_mem[rd_addr];
    end

endmodule

`default_nettype wire

[test/clp_placer_checker.sv]
// Response checker for the clear label placer: mirrors the store, predicts placements, compares.

module clp_placer_checker #(
    parameter int MAX_PLACED = 64
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            req_valid,
    input  wire                            req_stall,
    input  clp_pkg::clp_req_t              req,
    input  wire                            rsp_valid,
    input  wire                            rsp_stall,
    input  clp_pkg::clp_rsp_t              rsp,
    input  wire                            cfg_we,
    input  wire  [clp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [clp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import clp_pkg::*;

    // 1/sqrt(2) in Q0.16 and the rounding half for the diagonal offset
    localparam longint INV_ROOT2_Q16 = 46341;
    localparam longint HALF_Q16      = 32768;

    // Mirrored configuration
    logic [14:0]        clear_dist;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;

    // Mirrored rectangle store
    logic signed [15:0] box_x0 [MAX_PLACED];
    logic signed [15:0] box_y0 [MAX_PLACED];
    logic signed [15:0] box_x1 [MAX_PLACED];
    logic signed [15:0] box_y1 [MAX_PLACED];
    int                 boxes_held;

    clp_rsp_t           placements_due [$];
    int                 mismatches;

    // Clamp into [lo, hi] the way std::clamp does, then saturate to 16 bits
    function automatic longint fit_axis(longint v, longint lo, longint hi);
        longint r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        if (r < -32768)
            r = -32768;
        else if (r > 32767)
            r = 32767;
        return r;
    endfunction

    // Try the eight directions from east counterclockwise; fall back to the anchor
    function automatic clp_rsp_t place_label(clp_req_t q);
        longint   ax;
        longint   ay;
        longint   w;
        longint   h;
        longint   diag;
        longint   off;
        longint   px;
        longint   py;
        int       sx;
        int       sy;
        logic     blocked;
        clp_rsp_t pick;
        ax   = $signed(q.anchor_x);
        ay   = $signed(q.anchor_y);
        w    = longint'(q.label_w);
        h    = longint'(q.label_h);
        diag = (longint'(clear_dist) * INV_ROOT2_Q16 + HALF_Q16) >>> 16;
        pick.pos_x       = q.anchor_x;
        pick.pos_y       = q.anchor_y;
        pick.found_clear = 1'b0;
        for (int k = 0; k < 8 && !pick.found_clear; k++)
        begin
            // y grows downward, so north is a negative step
            case (k)
                0: begin sx =  1; sy =  0; end
                1: begin sx =  1; sy = -1; end
                2: begin sx =  0; sy = -1; end
                3: begin sx = -1; sy = -1; end
                4: begin sx = -1; sy =  0; end
                5: begin sx = -1; sy =  1; end
                6: begin sx =  0; sy =  1; end
                default: begin sx = 1; sy = 1; end
            endcase
            off = (sx != 0 && sy != 0) ? diag : longint'(clear_dist);
            px  = fit_axis(ax + sx * off, longint'(min_x), longint'(max_x) - w);
            py  = fit_axis(ay + sy * off, longint'(min_y), longint'(max_y) - h);
            // Strict overlap on both axes; far corner kept at full width
            blocked = 1'b0;
            for (int i = 0; i < boxes_held; i++)
            begin
                if (box_x0[i] < px + w && box_x1[i] > px && box_y0[i] < py + h && box_y1[i] > py)
                    blocked = 1'b1;
            end
            if (!blocked)
            begin
                pick.pos_x       = px[15:0];
                pick.pos_y       = py[15:0];
                pick.found_clear = 1'b1;
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clp_rsp_t want;
        if (!rst_n)
        begin
            clear_dist = CLEARANCE_RST;
            min_x      = VIEW_MIN_X_RST;
            min_y      = VIEW_MIN_Y_RST;
            max_x      = VIEW_MAX_X_RST;
            max_y      = VIEW_MAX_Y_RST;
            boxes_held = 0;
            placements_due.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Compare a response transfer with the oldest placement due
            if (rsp_valid && !rsp_stall)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("response with no placement due: pos_x %0d pos_y %0d found_clear %0b",
                           rsp.pos_x, rsp.pos_y, rsp.found_clear);
                    mismatches++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    if (rsp.pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, rsp.pos_x);
                        mismatches++;
                    end
                    if (rsp.pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, rsp.pos_y);
                        mismatches++;
                    end
                    if (rsp.found_clear !== want.found_clear)
                    begin
                        $error("found_clear: expected %0b, got %0b",
                               want.found_clear, rsp.found_clear);
                        mismatches++;
                    end
                end
            end

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CLEARANCE:  clear_dist = cfg_data[14:0];
                    REG_VIEW_MIN_X: min_x      = cfg_data;
                    REG_VIEW_MIN_Y: min_y      = cfg_data;
                    REG_VIEW_MAX_X: max_x      = cfg_data;
                    REG_VIEW_MAX_Y: max_y      = cfg_data;
                    default: ;
                endcase
            end

            // Apply a request transfer; a load into a full store is dropped
            if (req_valid && !req_stall)
            begin
                case (req.opcode)
                    OP_CLEAR: boxes_held = 0;
                    OP_LOAD:
                    begin
                        if (boxes_held < MAX_PLACED)
                        begin
                            box_x0[boxes_held] = req.rect_x0;
                            box_y0[boxes_held] = req.rect_y0;
                            box_x1[boxes_held] = req.rect_x1;
                            box_y1[boxes_held] = req.rect_y1;
                            boxes_held++;
                        end
                    end
                    OP_PLACE: placements_due.push_back(place_label(req));
                    default: ;
                endcase
            end

            pending    <= placements_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

[test/clear_label_placer_core_tb.sv]
// Testbench top for the clear label placer: stimulus, handshake pacing and the verdict.

module clear_label_placer_core_tb;
    import clp_pkg::*;

    localparam int     HALF_PERIOD = 5;
    localparam int     STORE_DEPTH = 64;
    localparam longint LIMIT       = 1000000;
    localparam int     LONG_HOLD   = 400;
    localparam int     PHASE_ITEMS = 75;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        int clear_dist;
        int min_x;
        int min_y;
        int max_x;
        int max_y;
    } view_setup_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    clp_req_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    clp_rsp_t              rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;

    int          send_idle_pct = 0;
    int          rsp_idle_pct  = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          counted       = 0;
    int          boxes_held    = 0;
    longint      cycle_count   = 0;
    view_setup_t cur;

    clear_label_placer_core #(
        .MAX_PLACED(STORE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    clp_placer_checker #(
        .MAX_PLACED(STORE_DEPTH)
    ) placer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the response side: a long hold when asked, otherwise at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            rsp_stall   <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    function automatic logic signed [15:0] to_coord(int v);
        if (v < -32768)
            return 16'sh8000;
        if (v > 32767)
            return 16'sh7fff;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] near(int c, int spread);
        return to_coord(c + int'($urandom_range(2 * spread)) - spread);
    endfunction

    // Pick a focus inside the viewport most of the time, anywhere otherwise
    function automatic int pick_axis(int lo, int hi);
        if (lo <= hi && $urandom_range(9) < 7)
            return lo + int'($urandom_range(hi - lo));
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Fill every field at random so that unused fields toggle too
    function automatic clp_req_t random_item();
        logic [$bits(clp_req_t)-1:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw;
    endfunction

    function automatic clp_req_t op_item(logic [1:0] op);
        clp_req_t item;
        item        = random_item();
        item.opcode = op;
        return item;
    endfunction

    function automatic clp_req_t load_item(int x0, int y0, int x1, int y1);
        clp_req_t item;
        item         = op_item(OP_LOAD);
        item.rect_x0 = to_coord(x0);
        item.rect_y0 = to_coord(y0);
        item.rect_x1 = to_coord(x1);
        item.rect_y1 = to_coord(y1);
        return item;
    endfunction

    function automatic clp_req_t place_item(int ax, int ay, int w, int h);
        clp_req_t item;
        item          = op_item(OP_PLACE);
        item.anchor_x = to_coord(ax);
        item.anchor_y = to_coord(ay);
        item.label_w  = w[14:0];
        item.label_h  = h[14:0];
        return item;
    endfunction

    function automatic view_setup_t phase_setup(int p);
        view_setup_t s;
        case (p)
            0: s = '{128, 0, 0, 20480, 11520};
            1: s = '{0, -32768, -32768, 32767, 32767};
            2: s = '{32767, 32767, 32767, -32768, -32768};
            3: s = '{300, -2000, -1500, 3000, 2500};
            4:
            begin
                s.clear_dist = $urandom_range(2000);
                s.min_x      = -int'($urandom_range(4000));
                s.min_y      = -int'($urandom_range(4000));
                s.max_x      = s.min_x + int'($urandom_range(8000));
                s.max_y      = s.min_y + int'($urandom_range(8000));
            end
            default:
            begin
                s.clear_dist = $urandom_range(32767);
                s.min_x      = int'($urandom_range(65535)) - 32768;
                s.min_y      = int'($urandom_range(65535)) - 32768;
                s.max_x      = int'($urandom_range(65535)) - 32768;
                s.max_y      = int'($urandom_range(65535)) - 32768;
            end
        endcase
        return s;
    endfunction

    // Offer one transfer, optionally after a random gap; return once it is taken
    task automatic offer(input clp_req_t item);
        bit taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        // Count only transfers that change something
        case (item.opcode)
            OP_CLEAR:
            begin
                boxes_held = 0;
                counted++;
            end
            OP_LOAD:
            begin
                if (boxes_held < STORE_DEPTH)
                begin
                    boxes_held++;
                    counted++;
                end
            end
            OP_PLACE: counted++;
            default: ;
        endcase
    endtask

    // Hold off the sender until every placement is back and the block is quiet
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    // Write all five registers back to back
    task automatic write_setup(input view_setup_t s);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CLEARANCE;
        cfg_data  <= {1'b0, s.clear_dist[14:0]};
        @(posedge clk);
        cfg_index <= REG_VIEW_MIN_X;
        cfg_data  <= s.min_x[15:0];
        @(posedge clk);
        cfg_index <= REG_VIEW_MIN_Y;
        cfg_data  <= s.min_y[15:0];
        @(posedge clk);
        cfg_index <= REG_VIEW_MAX_X;
        cfg_data  <= s.max_x[15:0];
        @(posedge clk);
        cfg_index <= REG_VIEW_MAX_Y;
        cfg_data  <= s.max_y[15:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One scene: mostly clear, load rectangles around a focus, then place labels there
    task automatic run_scene();
        int                 fx;
        int                 fy;
        int                 spread;
        int                 span;
        int                 size_cap;
        int                 n_boxes;
        int                 roll;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        clp_req_t           item;
        if ($urandom_range(99) < 8)
            offer(random_item());
        else
        begin
            fx       = pick_axis(cur.min_x, cur.max_x);
            fy       = pick_axis(cur.min_y, cur.max_y);
            spread   = (cur.clear_dist * 2 + 64 > 8000) ? 8000 : cur.clear_dist * 2 + 64;
            span     = spread / 2;
            size_cap = (cur.clear_dist + 48 > 4000) ? 4000 : cur.clear_dist + 48;
            if ($urandom_range(9) < 7)
                offer(op_item(OP_CLEAR));
            roll = $urandom_range(99);
            if (roll < 85)
                n_boxes = $urandom_range(8);
            else if (roll < 95)
                n_boxes = $urandom_range(9, 30);
            else
                n_boxes = $urandom_range(60, 70);
            repeat (n_boxes)
            begin
                x0 = near(fx, spread);
                y0 = near(fy, spread);
                x1 = to_coord(x0 + int'($urandom_range(span)));
                y1 = to_coord(y0 + int'($urandom_range(span)));
                item = load_item(x0, y0, x1, y1);
                // Swap corners now and then to load inverted rectangles
                if ($urandom_range(9) == 0)
                begin
                    item.rect_x0 = x1;
                    item.rect_x1 = x0;
                end
                if ($urandom_range(9) == 0)
                begin
                    item.rect_y0 = y1;
                    item.rect_y1 = y0;
                end
                offer(item);
            end
            repeat ($urandom_range(1, 4))
            begin
                item = op_item(OP_PLACE);
                item.anchor_x = near(fx, span);
                item.anchor_y = near(fy, span);
                if ($urandom_range(19) != 0)
                begin
                    item.label_w = 15'($urandom_range(size_cap));
                    item.label_h = 15'($urandom_range(size_cap));
                end
                offer(item);
            end
        end
    endtask

    initial
    begin
        int goal;
        bit paused;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks under the reset configuration
        offer(place_item(100, 100, 32, 16));
        offer(place_item(-32768, -32768, 0, 0));
        offer(place_item(32767, 32767, 32767, 32767));
        offer(place_item(-32768, 32767, 32767, 0));
        offer(load_item(-32768, -32768, 32767, 32767));
        offer(place_item(5000, 5000, 64, 32));
        offer(op_item(OP_CLEAR));
        // A box touching the east candidate edge, one blocking east, one inverted
        offer(load_item(1192, 1000, 1300, 1032));
        offer(load_item(1100, 990, 1150, 1010));
        offer(load_item(1300, 1100, 1000, 900));
        offer(place_item(1000, 1000, 64, 32));
        offer(op_item(OP_UNUSED));
        offer(place_item(20480, 11520, 100, 100));
        offer(load_item(2000, 2000, 2100, 2100));
        offer(place_item(1950, 2050, 0, 0));
        offer(op_item(OP_CLEAR));
        offer(place_item(1000, 1000, 64, 32));

        // Random scenes over several register settings and pacing modes
        for (int p = 0; p < 6; p++)
        begin
            drain();
            cur = phase_setup(p);
            write_setup(cur);
            send_idle_pct = (p < 2) ? 21 : (p < 4) ? 60 : 0;
            rsp_idle_pct  = (p < 2) ? 60 : (p < 4) ? 21 : 0;
            goal = counted + PHASE_ITEMS;
            if (p == 1)
            begin
                // Back up the block behind a long response stall
                hold_requests++;
                repeat (3)
                    offer(place_item(pick_axis(cur.min_x, cur.max_x),
                                     pick_axis(cur.min_y, cur.max_y),
                                     $urandom_range(200), $urandom_range(200)));
            end
            while (counted < goal)
            begin
                run_scene();
                if (p == 3 && !paused && counted >= goal - PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
src/clp_pkg.sv
src/clear_label_placer_core.sv
test/clp_placer_checker.sv
test/clear_label_placer_core_tb.sv
